>>> hdl/szb_pkg.sv
package szb_pkg;

  // Command codes on the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_SCALE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_KEY = 1'b1;

  // Fixed field widths
  localparam int unsigned IN_COORD_W = 11;
  localparam int unsigned SIDE_IN_W  = 7;
  localparam int unsigned ZOOM_IN_W  = 4;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned BOX_W      = 15;
  localparam int unsigned CFG_DATA_W = 8;

  // Saturation limits of a box coordinate
  localparam int BOX_MAX = 16383;
  localparam int BOX_MIN = -16384;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Per-pixel attributes carried from front to back
  typedef struct packed {
    logic               draw;
    logic               last;
    logic [COLOR_W-1:0] color;
  } szb_attr_t;

  localparam int unsigned ATTR_W = $bits(szb_attr_t);

endpackage

>>> hdl/szb_front.sv
module szb_front #(
  parameter int unsigned MAX_SIDE = 64,
  parameter int unsigned MAX_ZOOM = 8,
  parameter int unsigned COORD_W  = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [szb_pkg::COLOR_W-1:0]         transparent_key,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [szb_pkg::IN_COORD_W-1:0] in_origin_x,
  input  logic signed [szb_pkg::IN_COORD_W-1:0] in_origin_y,
  input  logic [szb_pkg::SIDE_IN_W-1:0]       in_sprite_width,
  input  logic [szb_pkg::SIDE_IN_W-1:0]       in_sprite_height,
  input  logic [szb_pkg::ZOOM_IN_W-1:0]       in_zoom,
  input  logic [szb_pkg::LEN_W-1:0]           in_sprite_length,
  input  logic [szb_pkg::COLOR_W-1:0]         in_pixel_color,
  output logic                                push,
  input  logic                                push_ready,
  output szb_pkg::szb_attr_t                  push_attr,
  output logic [4*COORD_W-1:0]                push_coords
);

  localparam int unsigned CW = $clog2(MAX_SIDE + 1);
  localparam int unsigned ZW = $clog2(MAX_ZOOM + 1);
  localparam int unsigned OW = $clog2(MAX_SIDE * MAX_ZOOM + 1);

  logic signed [szb_pkg::IN_COORD_W-1:0] base_x_r, base_x_nxt;
  logic signed [szb_pkg::IN_COORD_W-1:0] base_y_r, base_y_nxt;
  logic [CW-1:0]                width_r, width_nxt;
  logic [CW-1:0]                height_r, height_nxt;
  logic [ZW-1:0]                zoom_r, zoom_nxt;
  logic [szb_pkg::LEN_W-1:0]    length_r, length_nxt;
  logic [OW-1:0]                col_offset_r, col_offset_nxt;
  logic [OW-1:0]                row_offset_r, row_offset_nxt;
  logic [CW-1:0]                col_count_r, col_count_nxt;
  logic [CW-1:0]                row_count_r, row_count_nxt;
  logic [szb_pkg::LEN_W-1:0]    pixel_count_r, pixel_count_nxt;
  logic                         finished_r, finished_nxt;

  logic                         accept;
  logic                         done;
  logic                         opaque;
  logic [szb_pkg::LEN_W-1:0]    pixel_count_inc;
  logic signed [COORD_W-1:0]    x_left, y_top, x_right, y_bottom;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_command == szb_pkg::CMD_PIXEL);

  // Box corners from running sums
  assign x_left   = COORD_W'(base_x_r) + COORD_W'(col_offset_r);
  assign y_top    = COORD_W'(base_y_r) + COORD_W'(row_offset_r);
  assign x_right  = x_left + COORD_W'(zoom_r);
  assign y_bottom = y_top + COORD_W'(zoom_r);

  assign opaque          = in_pixel_color != transparent_key;
  assign pixel_count_inc = pixel_count_r + 1'b1;

  // End of draw: last pixel of last row, or stored pixel count reached
  always_comb begin
    done = (pixel_count_inc == length_r);
    if ((CW+1)'(col_count_r) + 1'b1 >= (CW+1)'(width_r) &&
        (CW+1)'(row_count_r) + 1'b1 >= (CW+1)'(height_r)) begin
      done = 1'b1;
    end
  end

  // Build the queue entry
  always_comb begin
    push_attr.draw  = !finished_r && opaque;
    push_attr.last  = !finished_r && done;
    push_attr.color = push_attr.draw ? in_pixel_color : '0;
    push_coords     = {x_left, y_top, x_right, y_bottom};
  end

  // Next state of the sprite registers and counters
  always_comb begin
    base_x_nxt      = base_x_r;
    base_y_nxt      = base_y_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    zoom_nxt        = zoom_r;
    length_nxt      = length_r;
    col_offset_nxt  = col_offset_r;
    row_offset_nxt  = row_offset_r;
    col_count_nxt   = col_count_r;
    row_count_nxt   = row_count_r;
    pixel_count_nxt = pixel_count_r;
    finished_nxt    = finished_r;
    if (accept) begin
      if (in_command == szb_pkg::CMD_START) begin
        base_x_nxt = in_origin_x;
        base_y_nxt = in_origin_y;
        // Clamp size and zoom into their supported ranges
        if (in_sprite_width == '0) begin
          width_nxt = CW'(1);
        end else if (32'(in_sprite_width) > MAX_SIDE) begin
          width_nxt = CW'(MAX_SIDE);
        end else begin
          width_nxt = CW'(in_sprite_width);
        end
        if (in_sprite_height == '0) begin
          height_nxt = CW'(1);
        end else if (32'(in_sprite_height) > MAX_SIDE) begin
          height_nxt = CW'(MAX_SIDE);
        end else begin
          height_nxt = CW'(in_sprite_height);
        end
        if (in_zoom == '0) begin
          zoom_nxt = ZW'(1);
        end else if (32'(in_zoom) > MAX_ZOOM) begin
          zoom_nxt = ZW'(MAX_ZOOM);
        end else begin
          zoom_nxt = ZW'(in_zoom);
        end
        length_nxt      = in_sprite_length;
        col_offset_nxt  = '0;
        row_offset_nxt  = '0;
        col_count_nxt   = '0;
        row_count_nxt   = '0;
        pixel_count_nxt = '0;
        finished_nxt    = 1'b0;
      end else if (!finished_r) begin
        // Advance column, wrap to next row at the row end
        if ((CW+1)'(col_count_r) + 1'b1 >= (CW+1)'(width_r)) begin
          col_count_nxt  = '0;
          col_offset_nxt = '0;
          row_count_nxt  = row_count_r + 1'b1;
          row_offset_nxt = row_offset_r + OW'(zoom_r);
        end else begin
          col_count_nxt  = col_count_r + 1'b1;
          col_offset_nxt = col_offset_r + OW'(zoom_r);
        end
        pixel_count_nxt = pixel_count_inc;
        finished_nxt    = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r      <= '0;
      base_y_r      <= '0;
      width_r       <= CW'(1);
      height_r      <= CW'(1);
      zoom_r        <= ZW'(1);
      length_r      <= szb_pkg::LEN_W'(1);
      col_offset_r  <= '0;
      row_offset_r  <= '0;
      col_count_r   <= '0;
      row_count_r   <= '0;
      pixel_count_r <= '0;
      finished_r    <= 1'b1;
    end else begin
      base_x_r      <= base_x_nxt;
      base_y_r      <= base_y_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      zoom_r        <= zoom_nxt;
      length_r      <= length_nxt;
      col_offset_r  <= col_offset_nxt;
      row_offset_r  <= row_offset_nxt;
      col_count_r   <= col_count_nxt;
      row_count_r   <= row_count_nxt;
      pixel_count_r <= pixel_count_nxt;
      finished_r    <= finished_nxt;
    end
  end

endmodule

>>> hdl/szb_queue.sv
module szb_queue #(
  parameter int unsigned WIDTH = 58
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned DEPTH = szb_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;

  assign push_ready = count_r != NW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];

  // Advance pointers, wrapping at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_ready || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue read while empty");

endmodule

>>> hdl/szb_back.sv
module szb_back #(
  parameter int unsigned COORD_W = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [szb_pkg::SCALE_W-1:0]       screen_scale,
  input  logic                              pop_valid,
  output logic                              pop,
  input  szb_pkg::szb_attr_t                pop_attr,
  input  logic [4*COORD_W-1:0]              pop_coords,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_draw,
  output logic signed [szb_pkg::BOX_W-1:0]  out_box_left,
  output logic signed [szb_pkg::BOX_W-1:0]  out_box_top,
  output logic signed [szb_pkg::BOX_W-1:0]  out_box_right,
  output logic signed [szb_pkg::BOX_W-1:0]  out_box_bottom,
  output logic [szb_pkg::COLOR_W-1:0]       out_fill_color,
  output logic                              out_last
);

  localparam int unsigned PW = COORD_W + szb_pkg::SCALE_W + 1;

  logic                                 out_valid_r, out_valid_nxt;
  logic                                 draw_r;
  logic                                 last_r;
  logic [szb_pkg::COLOR_W-1:0]          color_r;
  logic signed [szb_pkg::BOX_W-1:0]     left_r, top_r, right_r, bottom_r;
  logic signed [szb_pkg::BOX_W-1:0]     left_nxt, top_nxt, right_nxt, bottom_nxt;
  logic [szb_pkg::SCALE_W-1:0]          scale_eff;

  // Multiply by the screen scale and clip to the box range
  function automatic logic signed [szb_pkg::BOX_W-1:0] scale_sat(
    input logic signed [COORD_W-1:0]      coord,
    input logic [szb_pkg::SCALE_W-1:0]    scale
  );
    logic signed [PW-1:0] prod;
    prod = PW'(coord) * PW'($signed({1'b0, scale}));
    if (prod > PW'(szb_pkg::BOX_MAX)) begin
      scale_sat = szb_pkg::BOX_W'(szb_pkg::BOX_MAX);
    end else if (prod < PW'(szb_pkg::BOX_MIN)) begin
      scale_sat = szb_pkg::BOX_W'(szb_pkg::BOX_MIN);
    end else begin
      scale_sat = prod[szb_pkg::BOX_W-1:0];
    end
  endfunction

  assign scale_eff = (screen_scale == '0) ? szb_pkg::SCALE_W'(1) : screen_scale;
  assign pop       = pop_valid && (!out_valid_r || out_ready);

  // Zero the box when nothing is drawn
  always_comb begin
    left_nxt   = '0;
    top_nxt    = '0;
    right_nxt  = '0;
    bottom_nxt = '0;
    if (pop_attr.draw) begin
      left_nxt   = scale_sat(pop_coords[4*COORD_W-1:3*COORD_W], scale_eff);
      top_nxt    = scale_sat(pop_coords[3*COORD_W-1:2*COORD_W], scale_eff);
      right_nxt  = scale_sat(pop_coords[2*COORD_W-1:COORD_W], scale_eff);
      bottom_nxt = scale_sat(pop_coords[COORD_W-1:0], scale_eff);
    end
  end

  // Hold the result until the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      draw_r   <= pop_attr.draw;
      last_r   <= pop_attr.last;
      color_r  <= pop_attr.color;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_draw       = draw_r;
  assign out_last       = last_r;
  assign out_fill_color = color_r;
  assign out_box_left   = left_r;
  assign out_box_top    = top_r;
  assign out_box_right  = right_r;
  assign out_box_bottom = bottom_r;

  a_blank_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !draw_r) |-> (left_r == '0 && top_r == '0 && right_r == '0 &&
                                  bottom_r == '0 && color_r == '0))
    else $error("undrawn result carries box data");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && draw_r) |-> (left_r <= right_r && top_r <= bottom_r))
    else $error("box corners out of order");

endmodule

>>> hdl/sprite_zoom_box_expander_unit.sv
// Sprite zoom box expander: one pixel transfer in, one box result out.
// Path: an input transfer is written to a queue slot, then the scale multiply
// writes the output register, where the result is valid and can be transferred;
// start commands give no result.
// Throughput: 1 item per cycle while out_ready holds; a 2-entry queue decouples
// the counters from the scale stage, so either side may stall on its own.
// Reset (synchronous, rst_n low): scale 1, key 0, no draw active, queue empty.
module sprite_zoom_box_expander_unit #(
  parameter int unsigned MAX_SIDE = 64,
  parameter int unsigned MAX_ZOOM = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [szb_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [szb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic signed [szb_pkg::IN_COORD_W-1:0] in_origin_x,
  input  logic signed [szb_pkg::IN_COORD_W-1:0] in_origin_y,
  input  logic [szb_pkg::SIDE_IN_W-1:0]         in_sprite_width,
  input  logic [szb_pkg::SIDE_IN_W-1:0]         in_sprite_height,
  input  logic [szb_pkg::ZOOM_IN_W-1:0]         in_zoom,
  input  logic [szb_pkg::LEN_W-1:0]             in_sprite_length,
  input  logic [szb_pkg::COLOR_W-1:0]           in_pixel_color,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_draw,
  output logic signed [szb_pkg::BOX_W-1:0]      out_box_left,
  output logic signed [szb_pkg::BOX_W-1:0]      out_box_top,
  output logic signed [szb_pkg::BOX_W-1:0]      out_box_right,
  output logic signed [szb_pkg::BOX_W-1:0]      out_box_bottom,
  output logic [szb_pkg::COLOR_W-1:0]           out_fill_color,
  output logic                                  out_last
);

  localparam int unsigned OW      = $clog2(MAX_SIDE * MAX_ZOOM + 1);
  localparam int unsigned COORD_W = ((OW > 10) ? OW : 10) + 2;
  localparam int unsigned ENTRY_W = szb_pkg::ATTR_W + 4 * COORD_W;

  logic [szb_pkg::SCALE_W-1:0] screen_scale_r;
  logic [szb_pkg::COLOR_W-1:0] transparent_key_r;

  logic                        push, push_ready;
  szb_pkg::szb_attr_t          push_attr, pop_attr;
  logic [4*COORD_W-1:0]        push_coords, pop_coords;
  logic                        pop_valid, pop;
  logic [ENTRY_W-1:0]          pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_scale_r    <= szb_pkg::SCALE_W'(1);
      transparent_key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        szb_pkg::REG_SCREEN_SCALE:    screen_scale_r    <= cfg_wdata[szb_pkg::SCALE_W-1:0];
        szb_pkg::REG_TRANSPARENT_KEY: transparent_key_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  szb_front #(
    .MAX_SIDE (MAX_SIDE),
    .MAX_ZOOM (MAX_ZOOM),
    .COORD_W  (COORD_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .transparent_key  (transparent_key_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_sprite_width  (in_sprite_width),
    .in_sprite_height (in_sprite_height),
    .in_zoom          (in_zoom),
    .in_sprite_length (in_sprite_length),
    .in_pixel_color   (in_pixel_color),
    .push             (push),
    .push_ready       (push_ready),
    .push_attr        (push_attr),
    .push_coords      (push_coords)
  );

  szb_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_data  ({push_attr, push_coords}),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  assign pop_attr   = pop_data[ENTRY_W-1:4*COORD_W];
  assign pop_coords = pop_data[4*COORD_W-1:0];

  szb_back #(
    .COORD_W (COORD_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .screen_scale   (screen_scale_r),
    .pop_valid      (pop_valid),
    .pop            (pop),
    .pop_attr       (pop_attr),
    .pop_coords     (pop_coords),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_draw       (out_draw),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_right  (out_box_right),
    .out_box_bottom (out_box_bottom),
    .out_fill_color (out_fill_color),
    .out_last       (out_last)
  );

endmodule
